// File: src/cau_pkg.sv
// Package for the complex arithmetic unit: operation codes, widths and
// pipeline payload types. No dependencies.
package cau_pkg;

  localparam int FracBitsDefault = 16;
  localparam int DataW = 32;
  localparam int ProdW = 64;
  localparam int SumW = 65;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_CMP = 3'd4
  } op_t;

  typedef struct packed {
    logic [2:0] action;
    logic       eq;
    logic       dz;
  } ctl_t;

endpackage

// File: src/cau_prod.sv
// Product stage of the complex arithmetic unit: six 32x32 signed products,
// then the two cross sums (operand sums for add/sub) and the divisor norm. Depends on cau_pkg.
module cau_prod
  import cau_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  ctl_t                   in_ctl,
  input  logic signed [DataW-1:0] a_re,
  input  logic signed [DataW-1:0] a_im,
  input  logic signed [DataW-1:0] b_re,
  input  logic signed [DataW-1:0] b_im,
  output logic                   out_v,
  output ctl_t                   out_ctl,
  output logic signed [SumW-1:0] num_re,
  output logic signed [SumW-1:0] num_im,
  output logic        [SumW-1:0] den
);

  logic                   v1_r, v2_r;
  ctl_t                   c1_r, c2_r;
  logic signed [ProdW-1:0] rr_r, ii_r, ir_r, ri_r, bb_r, cc_r;
  logic signed [DataW-1:0] ar_r, ai_r, br_r, bi_r;
  logic signed [SumW-1:0] nre_r, nim_r;
  logic        [SumW-1:0] den_r;
  logic                   is_div;

  assign is_div = (c1_r.action == OP_DIV);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_v;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1_r <= in_ctl;
      ar_r <= a_re;
      ai_r <= a_im;
      br_r <= b_re;
      bi_r <= b_im;
      rr_r <= a_re * b_re;
      ii_r <= a_im * b_im;
      ir_r <= a_im * b_re;
      ri_r <= a_re * b_im;
      bb_r <= b_re * b_re;
      cc_r <= b_im * b_im;
      c2_r <= c1_r;
      den_r <= SumW'($unsigned(bb_r)) + SumW'($unsigned(cc_r));
      if (c1_r.action == OP_ADD) begin
        nre_r <= SumW'(ar_r) + SumW'(br_r);
        nim_r <= SumW'(ai_r) + SumW'(bi_r);
      end else if (c1_r.action == OP_SUB) begin
        nre_r <= SumW'(ar_r) - SumW'(br_r);
        nim_r <= SumW'(ai_r) - SumW'(bi_r);
      end else begin
        nre_r <= is_div ? SumW'(rr_r) + SumW'(ii_r) : SumW'(rr_r) - SumW'(ii_r);
        nim_r <= is_div ? SumW'(ir_r) - SumW'(ri_r) : SumW'(ir_r) + SumW'(ri_r);
      end
    end
  end

  assign out_v = v2_r;
  assign out_ctl = c2_r;
  assign num_re = nre_r;
  assign num_im = nim_r;
  assign den = den_r;

endmodule

// File: src/cau_div.sv
// Pipelined restoring divider, one quotient bit per stage, with truncation
// toward zero and Q-format saturation; bypass gives zero. Depends on cau_pkg.
module cau_div
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_v,
  input  logic signed [SumW-1:0] num,
  input  logic        [SumW-1:0] den,
  input  logic                   bypass,
  output logic                   out_v,
  output logic signed [DataW-1:0] q,
  output logic                   sat
);

  localparam int QW = DataW + 1;
  localparam int Steps = QW;
  localparam int MagW = SumW + FRAC_BITS;
  localparam int RemW = SumW + 1;

  logic          v_r   [Steps+1];
  logic          neg_r [Steps+1];
  logic          byp_r [Steps+1];
  logic          big_r [Steps+1];
  logic [MagW-1:0] mag_r [Steps+1];
  logic [SumW-1:0] den_r [Steps+1];
  logic [RemW-1:0] rem_r [Steps+1];
  logic [QW-1:0]   quo_r [Steps+1];
  logic [SumW-1:0] nmag;
  logic [MagW-1:0] shifted;
  logic [QW:0]     lim;

  assign nmag = num[SumW-1] ? SumW'(-num) : SumW'(num);
  assign shifted = MagW'(nmag) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i <= Steps; i++) v_r[i] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_v;
      for (int i = 1; i <= Steps; i++) v_r[i] <= v_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0] <= num[SumW-1];
      byp_r[0] <= bypass;
      den_r[0] <= den;
      mag_r[0] <= shifted;
      // The bits above the quotient window form the starting remainder.
      rem_r[0] <= RemW'(shifted >> QW);
      quo_r[0] <= '0;
      // Quotient at or above 2^QW always saturates; checked by a compare.
      big_r[0] <= (den != '0) &&
                  ((shifted >> QW) >= MagW'(den));
      for (int i = 1; i <= Steps; i++) begin
        logic [RemW-1:0] t;
        t = {rem_r[i-1][RemW-2:0], mag_r[i-1][QW-i]};
        neg_r[i] <= neg_r[i-1];
        byp_r[i] <= byp_r[i-1];
        big_r[i] <= big_r[i-1];
        den_r[i] <= den_r[i-1];
        mag_r[i] <= mag_r[i-1];
        if (t >= RemW'(den_r[i-1])) begin
          rem_r[i] <= t - RemW'(den_r[i-1]);
          quo_r[i] <= {quo_r[i-1][QW-2:0], 1'b1};
        end else begin
          rem_r[i] <= t;
          quo_r[i] <= {quo_r[i-1][QW-2:0], 1'b0};
        end
      end
    end
  end

  assign lim = neg_r[Steps] ? (QW+1)'(34'h080000000) : (QW+1)'(34'h07FFFFFFF);

  always_comb begin
    logic over;
    over = big_r[Steps] || ({1'b0, quo_r[Steps]} > lim);
    sat = 1'b0;
    q = '0;
    if (!byp_r[Steps]) begin
      sat = over;
      if (over)
        q = neg_r[Steps] ? 32'sh80000000 : 32'sh7FFFFFFF;
      else
        q = neg_r[Steps] ? DataW'(-quo_r[Steps]) : DataW'(quo_r[Steps]);
    end
  end

  assign out_v = v_r[Steps];

endmodule

// File: src/cau_fmt.sv
// Format stage: shift, saturate and merge the per-operation results for one
// item. Depends on cau_pkg.
module cau_fmt
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  ctl_t                    ctl,
  input  logic signed [SumW-1:0]  sum_re,
  input  logic signed [SumW-1:0]  sum_im,
  input  logic signed [DataW-1:0] div_re,
  input  logic signed [DataW-1:0] div_im,
  input  logic                    div_sat,
  output logic [DataW-1:0]        res_re,
  output logic [DataW-1:0]        res_im,
  output logic                    sat
);

  function automatic logic [DataW:0] clamp(input logic signed [SumW-1:0] v);
    logic signed [SumW-1:0] hi, lo;
    hi = SumW'(33'sh07FFFFFFF);
    lo = -SumW'(33'sh080000000);
    if (v > hi) clamp = {1'b1, 32'h7FFFFFFF};
    else if (v < lo) clamp = {1'b1, 32'h80000000};
    else clamp = {1'b0, v[DataW-1:0]};
  endfunction

  logic signed [SumW-1:0] tr, ti;
  logic [DataW:0] cr, ci;

  always_comb begin
    tr = sum_re;
    ti = sum_im;
    if (ctl.action == OP_MUL) begin
      // Truncate toward zero: shift the magnitude.
      tr = sum_re[SumW-1] ? -((-sum_re) >>> FRAC_BITS) : sum_re >>> FRAC_BITS;
      ti = sum_im[SumW-1] ? -((-sum_im) >>> FRAC_BITS) : sum_im >>> FRAC_BITS;
    end
    cr = clamp(tr);
    ci = clamp(ti);
    res_re = '0;
    res_im = '0;
    sat = 1'b0;
    case (ctl.action)
      OP_ADD, OP_SUB, OP_MUL: begin
        res_re = cr[DataW-1:0];
        res_im = ci[DataW-1:0];
        sat = cr[DataW] | ci[DataW];
      end
      OP_DIV: begin
        res_re = div_re;
        res_im = div_im;
        sat = div_sat;
      end
      default: ;
    endcase
  end

endmodule

// File: src/complex_arith_unit.sv
// Top level of the complex arithmetic unit: input register, product stages,
// divider pipeline, formatting and output skid. Uses cau_pkg and submodules.
//
// Usage: requests enter on the in_ stream (tuser = action, tdata = a_re,
// a_im, b_re, b_im) and one result leaves on the out_ stream per request.
// Every operation goes through the same pipeline of 37 register stages; its
// length is set by the 33 quotient-bit stages of the divider. Throughput is
// one request per cycle while out_tready stays high. The whole pipeline
// advances only when the two-entry output buffer can take what leaves the
// last stage. in_tready drops only while a result waits in the buffer and
// another one sits in the last stage, and it follows out_tready in the same
// cycle, so a stall on out_tready holds all requests in place and nothing is
// lost or repeated.
// Reset clears all valid bits; no request is in flight afterward.
// Results of the compare action carry only is_equal; divide by a zero
// divisor gives zero parts with div_zero set. Unused action codes give an
// all-zero result.
module complex_arith_unit
  import cau_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // a_re, a_im, b_re, b_im
  input  logic [2:0]   in_tuser,  // action
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata, // res_re, res_im
  output logic [2:0]   out_tuser  // is_equal, div_zero, saturated
);

  logic en, pv;
  ctl_t ctl0, pctl;
  logic signed [SumW-1:0] nre, nim;
  logic [SumW-1:0] den;
  logic dv_re, dv_im;
  logic signed [DataW-1:0] qre, qim;
  logic sre, sim;
  localparam int DivLat = DataW + 2;
  ctl_t cd_r [DivLat];
  logic signed [SumW-1:0] sre_r [DivLat];
  logic signed [SumW-1:0] sim_r [DivLat];
  logic [DataW-1:0] fre, fim;
  logic fsat;
  logic [66:0] fq_r [2];
  logic [1:0] cnt_r;
  logic [66:0] head;
  logic push, pop;

  assign ctl0.action = in_tuser;
  assign ctl0.eq = (in_tuser == OP_CMP) && (in_tdata[31:0] == in_tdata[95:64]) &&
                   (in_tdata[63:32] == in_tdata[127:96]);
  assign ctl0.dz = (in_tuser == OP_DIV) && (in_tdata[95:64] == '0) &&
                   (in_tdata[127:96] == '0);

  // Advance while the skid buffer has room for everything in flight there.
  assign en = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && !dv_re) || pop;
  assign in_tready = en;

  cau_prod u_prod (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(in_tvalid && en), .in_ctl(ctl0),
    .a_re(in_tdata[31:0]), .a_im(in_tdata[63:32]),
    .b_re(in_tdata[95:64]), .b_im(in_tdata[127:96]),
    .out_v(pv), .out_ctl(pctl), .num_re(nre), .num_im(nim), .den(den)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_re (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(pv), .num(nre), .den(den),
    .bypass(pctl.action != OP_DIV || pctl.dz), .out_v(dv_re), .q(qre), .sat(sre)
  );

  cau_div #(.FRAC_BITS(FRAC_BITS)) u_div_im (
    .clk(clk), .rst_n(rst_n), .en(en), .in_v(pv), .num(nim), .den(den),
    .bypass(pctl.action != OP_DIV || pctl.dz), .out_v(dv_im), .q(qim), .sat(sim)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      cd_r[0] <= pctl;
      sre_r[0] <= nre;
      sim_r[0] <= nim;
      for (int i = 1; i < DivLat; i++) begin
        cd_r[i] <= cd_r[i-1];
        sre_r[i] <= sre_r[i-1];
        sim_r[i] <= sim_r[i-1];
      end
    end
  end

  cau_fmt #(.FRAC_BITS(FRAC_BITS)) u_fmt (
    .ctl(cd_r[DivLat-1]), .sum_re(sre_r[DivLat-1]), .sum_im(sim_r[DivLat-1]),
    .div_re(qre), .div_im(qim), .div_sat(sre | sim),
    .res_re(fre), .res_im(fim), .sat(fsat)
  );

  assign head = {fsat && !cd_r[DivLat-1].dz, cd_r[DivLat-1].dz, cd_r[DivLat-1].eq,
                 fim, fre};
  assign push = en && dv_re && dv_im;
  assign pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fq_r[0] <= (push && (cnt_r == 2'd1)) ? head : fq_r[1];
      if (push && (cnt_r == 2'd2)) fq_r[1] <= head;
    end else if (push) begin
      fq_r[cnt_r[0]] <= head;
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata = fq_r[0][63:0];
  assign out_tuser = fq_r[0][66:64];

endmodule
